@@ hw/rtl/keyed_slot_table_lru_timeout_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the keyed slot table.
// Each macro expects clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_LRU_TIMEOUT_TOP_ASSERT_SVH
`define KEYED_SLOT_TABLE_LRU_TIMEOUT_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define KSL_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define KSL_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ hw/rtl/ksl_pkg.sv @@
// ---------------------------------------------------------------------------
// ksl_pkg
// Types and constants shared by the keyed slot table modules.
// ---------------------------------------------------------------------------
package ksl_pkg;

  // Reset value of the idle timeout register, in ms.
  localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd2000;

  // Item codes carried in the func field.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_TOUCH = 1'b1;

  // Input item.
  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] time_ms;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        hit;
    logic [6:0]  slot;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [7:0]  expired_count;
  } out_item_t;

  // One table entry as it moves around the ring of cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] seen;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLAIM,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/ksl_cell.sv @@
// ---------------------------------------------------------------------------
// ksl_cell
// One storage cell of the slot ring: holds one entry and passes it on.
// ---------------------------------------------------------------------------
module ksl_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  ksl_pkg::entry_t d,
  output ksl_pkg::entry_t q
);

  // The valid bit is cleared by reset so the table starts empty.
  // Key and last-seen time only matter while the entry is valid.
  always_ff @(posedge clk) begin
    if (shift) begin
      q.key  <= d.key;
      q.seen <= d.seen;
    end
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
  end

endmodule

@@ hw/rtl/ksl_ctrl.sv @@
// ---------------------------------------------------------------------------
// ksl_ctrl
// Scan controller: watches the entry leaving the ring, updates it on its
// way back in, and builds the result item for each input item.
// ---------------------------------------------------------------------------
module ksl_ctrl #(
  parameter int SLOTS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ksl_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ksl_pkg::out_item_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  ksl_pkg::entry_t   head,
  output ksl_pkg::entry_t   feed,
  output logic              shift
);

  localparam int IW = $clog2(SLOTS);

  ksl_pkg::state_t state, state_next;

  logic [IW-1:0] idx;
  logic          last;
  logic          accept;
  logic          can_load;

  logic          func_r;
  logic [31:0]   key_r;
  logic [31:0]   cur_time;
  logic [31:0]   idle_timeout;

  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          have_free;
  logic [IW-1:0] free_idx;
  logic          have_lru;
  logic [IW-1:0] lru_idx;
  logic [31:0]   lru_seen;
  logic [IW-1:0] pick;
  logic [31:0]   evk;
  logic [7:0]    freed;

  logic [31:0]   idle_age;
  logic          expire;
  logic          key_hit;
  logic          take_free;
  logic          take_lru;
  logic          at_pick;

  assign accept   = in_valid && !in_stall;
  assign last     = (idx == IW'(SLOTS - 1));
  assign can_load = !out_valid || !out_stall;

  // Checks on the entry at the ring head.
  assign idle_age  = cur_time - head.seen;
  assign expire    = head.valid && (idle_age > idle_timeout);
  assign key_hit   = head.valid && (head.key == key_r) && !hit_found;
  assign take_free = !head.valid && !have_free;
  assign take_lru  = head.valid && !key_hit && (!have_lru || (head.seen < lru_seen));
  assign pick      = have_free ? free_idx : lru_idx;
  assign at_pick   = (idx == pick);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ksl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ksl_pkg::ST_SCAN;
        end
      end
      ksl_pkg::ST_SCAN: begin
        if (last) begin
          if (func_r == ksl_pkg::FUNC_TOUCH && !hit_found && !key_hit) begin
            state_next = ksl_pkg::ST_CLAIM;
          end else begin
            state_next = ksl_pkg::ST_FINISH;
          end
        end
      end
      ksl_pkg::ST_CLAIM: begin
        if (last) begin
          state_next = ksl_pkg::ST_FINISH;
        end
      end
      ksl_pkg::ST_FINISH: begin
        if (can_load) begin
          state_next = ksl_pkg::ST_IDLE;
        end
      end
      default: state_next = ksl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: ring control and the entry fed back in.
  always_comb begin
    in_stall = 1'b1;
    shift    = 1'b0;
    feed     = head;
    unique case (state)
      ksl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      ksl_pkg::ST_SCAN: begin
        shift = 1'b1;
        if (func_r == ksl_pkg::FUNC_TICK) begin
          if (expire) begin
            feed.valid = 1'b0;
          end
        end else if (key_hit) begin
          feed.seen = cur_time;
        end
      end
      ksl_pkg::ST_CLAIM: begin
        shift = 1'b1;
        if (at_pick) begin
          feed.valid = 1'b1;
          feed.key   = key_r;
          feed.seen  = cur_time;
        end
      end
      ksl_pkg::ST_FINISH: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // State, current time, timeout register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ksl_pkg::ST_IDLE;
      cur_time     <= '0;
      idle_timeout <= ksl_pkg::IDLE_TIMEOUT_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        idle_timeout <= cfg_wr_data;
      end
      if (accept && in_data.func == ksl_pkg::FUNC_TICK) begin
        cur_time <= in_data.time_ms;
      end
      if (state == ksl_pkg::ST_FINISH && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan position and the running search results of one pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_data.func;
      key_r     <= in_data.key;
      idx       <= '0;
      hit_found <= 1'b0;
      have_free <= 1'b0;
      have_lru  <= 1'b0;
      freed     <= '0;
      evk       <= '0;
    end else if (state == ksl_pkg::ST_SCAN) begin
      idx <= last ? '0 : idx + 1'b1;
      if (func_r == ksl_pkg::FUNC_TICK) begin
        if (expire && freed != 8'hFF) begin
          freed <= freed + 8'd1;
        end
      end else begin
        if (key_hit) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (take_free) begin
          have_free <= 1'b1;
          free_idx  <= idx;
        end
        if (take_lru) begin
          have_lru <= 1'b1;
          lru_idx  <= idx;
          lru_seen <= head.seen;
        end
      end
    end else if (state == ksl_pkg::ST_CLAIM) begin
      idx <= last ? '0 : idx + 1'b1;
      if (at_pick && !have_free) begin
        evk <= head.key;
      end
    end
  end

  // Result item register.
  always_ff @(posedge clk) begin
    if (state == ksl_pkg::ST_FINISH && can_load) begin
      if (func_r == ksl_pkg::FUNC_TOUCH) begin
        out_data.hit           <= hit_found;
        out_data.slot          <= hit_found ? 7'(hit_idx) : 7'(pick);
        out_data.evicted       <= !hit_found && !have_free;
        out_data.evicted_key   <= evk;
        out_data.expired_count <= '0;
      end else begin
        out_data.hit           <= 1'b0;
        out_data.slot          <= '0;
        out_data.evicted       <= 1'b0;
        out_data.evicted_key   <= '0;
        out_data.expired_count <= freed;
      end
    end
  end

endmodule

@@ hw/rtl/keyed_slot_table_lru_timeout_top.sv @@
// ---------------------------------------------------------------------------
// keyed_slot_table_lru_timeout_top
// Fully associative key table with least-recently-seen replacement and
// idle timeout, stored in a ring of entry cells scanned by one controller.
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   in        in_valid / in_stall    in_data  (func, key, time_ms)
//   out       out_valid / out_stall  out_data (hit, slot, evicted, ...)
//   config    cfg_wr_en              cfg_wr_data (idle_timeout)
//
// A tick or a touch that hits takes one full rotation of the ring;
// a touch that misses takes a second rotation to claim its slot.
// The cell ring turns one entry per cycle while the controller scans.
// Reset empties the table at once and loads the timeout with 2000.
// A stalled result waits in the output register while the next item runs.
// ---------------------------------------------------------------------------
`include "keyed_slot_table_lru_timeout_top_assert.svh"

module keyed_slot_table_lru_timeout_top #(
  parameter int SLOTS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ksl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ksl_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  ksl_pkg::entry_t ring [SLOTS];
  ksl_pkg::entry_t feed;
  ksl_pkg::entry_t head;
  logic            shift;

  // The entry leaving the last cell is examined and fed back into the first.
  assign head = ring[SLOTS-1];

  ksl_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .head       (head),
    .feed       (feed),
    .shift      (shift)
  );

  // Ring of cells, each passing its entry to the next while the ring turns.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_first
      ksl_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (feed),
        .q    (ring[k])
      );
    end else begin : g_rest
      ksl_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (ring[k-1]),
        .q    (ring[k])
      );
    end
  end

  // An accepted item keeps the input side closed while it is worked on.
  `KSL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  // A result never reports both a hit and an eviction.
  `KSL_ASSERT_SAME(a_hit_no_evict, out_valid, !(out_data.hit && out_data.evicted), "hit with eviction")

  // A result with freed slots is a tick result with no touch fields set.
  `KSL_ASSERT_SAME(a_tick_fields, out_valid && out_data.expired_count != 8'd0,
                   !out_data.hit && out_data.slot == 7'd0 && !out_data.evicted,
                   "touch fields on a tick result")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the keyed slot table with LRU replacement and idle timeout
//
// Touch and tick items go through the valid/stall input channel. A scoreboard
// model of the table predicts one result per accepted item. Each delivered
// result is compared field by field with the oldest prediction. The sender
// and the receiver idle at random in two phases and not at all in a third. The idle timeout register
// is reprogrammed between and within tests, only while the table is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS     = 128;
  localparam int END_CYCLES = 2 * NSLOTS + 40;
  localparam int LIMIT      = 1_500_000;
  localparam int POOL_SIZE  = 192;
  localparam int MAX_PRINTS = 100;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  ksl_pkg::in_item_t  in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  ksl_pkg::out_item_t out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [31:0]        cfg_wr_data = '0;

  // Scoreboard copy of the table and its configuration.
  bit          tbl_valid [NSLOTS];
  bit   [31:0] tbl_key   [NSLOTS];
  bit   [31:0] tbl_seen  [NSLOTS];
  logic [31:0] now_ms = '0;
  logic [31:0] tmo_ms = ksl_pkg::IDLE_TIMEOUT_RESET;

  ksl_pkg::out_item_t pending_results [$];
  ksl_pkg::out_item_t oldest_result;
  int          err_count      = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  keyed_slot_table_lru_timeout_top #(
    .SLOTS(NSLOTS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got,
               cycle_count);
  endtask

  // Apply one item to the scoreboard table and return the result it causes.
  function automatic ksl_pkg::out_item_t predict_table(input ksl_pkg::in_item_t item);
    ksl_pkg::out_item_t res;
    int          hit_i;
    int          free_i;
    int          lru_i;
    int          pick;
    int          freed;
    logic [31:0] idle;
    res = '0;
    if (item.func == ksl_pkg::FUNC_TICK) begin
      // A tick loads the new time and frees every slot idle too long.
      now_ms = item.time_ms;
      freed  = 0;
      for (int i = 0; i < NSLOTS; i++) begin
        idle = item.time_ms - tbl_seen[i];
        if (tbl_valid[i] && idle > tmo_ms) begin
          tbl_valid[i] = 1'b0;
          if (freed < 255) freed++;
        end
      end
      res.expired_count = freed[7:0];
    end else begin
      // A touch looks for its key first.
      hit_i = -1;
      for (int i = 0; i < NSLOTS && hit_i < 0; i++)
        if (tbl_valid[i] && tbl_key[i] == item.key) hit_i = i;
      if (hit_i >= 0) begin
        tbl_seen[hit_i] = now_ms;
        res.hit  = 1'b1;
        res.slot = hit_i[6:0];
      end else begin
        // On a miss take the lowest free slot, else the oldest valid one.
        free_i = -1;
        lru_i  = -1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!tbl_valid[i]) begin
            if (free_i < 0) free_i = i;
          end else if (lru_i < 0 || tbl_seen[i] < tbl_seen[lru_i]) begin
            lru_i = i;
          end
        end
        if (free_i >= 0) begin
          pick = free_i;
        end else begin
          pick = lru_i;
          res.evicted     = 1'b1;
          res.evicted_key = tbl_key[pick];
        end
        tbl_valid[pick] = 1'b1;
        tbl_key[pick]   = item.key;
        tbl_seen[pick]  = now_ms;
        res.slot = pick[6:0];
      end
    end
    return res;
  endfunction

  // Build a touch item; the unused time field carries noise.
  function automatic ksl_pkg::in_item_t make_touch(input logic [31:0] key);
    ksl_pkg::in_item_t item;
    item.func    = ksl_pkg::FUNC_TOUCH;
    item.key     = key;
    item.time_ms = $urandom;
    return item;
  endfunction

  // Build a tick item; the unused key field carries noise.
  function automatic ksl_pkg::in_item_t make_tick(input logic [31:0] t);
    ksl_pkg::in_item_t item;
    item.func    = ksl_pkg::FUNC_TICK;
    item.key     = $urandom;
    item.time_ms = t;
    return item;
  endfunction

  // Send one item, with random idle cycles in front of it.
  task automatic send_item(input ksl_pkg::in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_table(item));
  endtask

  // Stop sending and wait until every predicted result has been delivered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Program the idle timeout while the table is idle.
  task automatic write_idle_timeout(input logic [31:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tmo_ms = value;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Result checker and random receiver stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, slot", '0, 32'(out_data.slot));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.hit !== oldest_result.hit)
          report_mismatch("hit", 32'(oldest_result.hit), 32'(out_data.hit));
        if (out_data.slot !== oldest_result.slot)
          report_mismatch("slot", 32'(oldest_result.slot), 32'(out_data.slot));
        if (out_data.evicted !== oldest_result.evicted)
          report_mismatch("evicted", 32'(oldest_result.evicted),
                          32'(out_data.evicted));
        if (out_data.evicted_key !== oldest_result.evicted_key)
          report_mismatch("evicted_key", oldest_result.evicted_key,
                          out_data.evicted_key);
        if (out_data.expired_count !== oldest_result.expired_count)
          report_mismatch("expired_count", 32'(oldest_result.expired_count),
                          32'(out_data.expired_count));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Hits, misses, timeout edges and time wrap with the reset timeout of 2000.
  task automatic test_basic_touch_tick();
    send_item(make_touch(32'h0000_0000));
    send_item(make_touch(32'hFFFF_FFFF));
    // A hit at an unchanged time still rewrites the last-seen time.
    send_item(make_touch(32'h0000_0000));
    // Idle equal to the timeout keeps the slots.
    send_item(make_tick(32'd2000));
    send_item(make_touch(32'hFFFF_FFFF));
    send_item(make_tick(32'd2001));
    send_item(make_touch(32'h0000_0000));
    send_item(make_tick(32'hFFFF_FFFF));
    send_item(make_touch(32'h1234_5678));
    // Time wraps; the idle time is a small positive value.
    send_item(make_tick(32'h0000_0000));
    send_item(make_tick(32'd5));
    send_item(make_touch(32'hAAAA_AAAA));
    send_item(make_touch(32'h5555_5555));
    send_item(make_tick(32'd2004));
    send_item(make_touch(32'h1234_5678));
    send_item(make_touch(32'h5555_5555));
    send_item(make_tick(32'd2006));
  endtask

  // Fill the whole table, force evictions, then expire every slot at once.
  task automatic test_fill_and_evict();
    logic [31:0] t;
    write_idle_timeout(32'hFFFF_FFFF);
    t = 32'h8000_0000 + $urandom_range(0, 1000);
    for (int n = 0; n < NSLOTS + 24; n++) begin
      if (n % 16 == 0) begin
        t = t + $urandom_range(1, 50);
        send_item(make_tick(t));
      end
      send_item(make_touch($urandom));
    end
    // With no idle allowed, one ms later every slot is freed.
    write_idle_timeout(32'd0);
    send_item(make_tick(t + 32'd1));
    write_idle_timeout(ksl_pkg::IDLE_TIMEOUT_RESET);
  endtask

  // Random touches over a key pool mixed with ticks that advance the time.
  task automatic test_random_traffic(input int count, input logic [31:0] timeout);
    logic [31:0] key_pool [POOL_SIZE];
    int          sel;
    write_idle_timeout(timeout);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 62)
        send_item(make_touch(key_pool[$urandom_range(0, POOL_SIZE - 1)]));
      else if (sel < 70)
        send_item(make_touch($urandom));
      else if (sel < 96)
        send_item(make_tick(now_ms + $urandom_range(0, 600)));
      else if (sel < 98)
        send_item(make_tick($urandom));
      else
        send_item(make_tick(32'hFFFF_FFFF - $urandom_range(0, 400)));
    end
  endtask

  // Test sequence.
  initial begin
    set_idle(10, 77);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_basic_touch_tick();
    test_fill_and_evict();
    test_random_traffic(300, $urandom_range(500, 3000));

    set_idle(77, 10);
    test_random_traffic(150, 32'd0);
    test_random_traffic(150, 32'hFFFF_FFFF);

    set_idle(0, 0);
    test_random_traffic(300, 32'd1500);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
